[rtl/drac_pkg.sv]
package drac_pkg;

  localparam int MAX_RECTS = 16;
  localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CNT_W = $clog2(MAX_RECTS + 1);

  localparam int COORD_W = 15;
  localparam int SIZE_W = 16;
  localparam int EXT_W = 18;
  localparam int AREA_W = 36;
  localparam int PROD_W = 2 * SIZE_W;

  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_QUERY   = 3'd1;
  localparam logic [2:0] CMD_CLIP    = 3'd2;
  localparam logic [2:0] CMD_SETFULL = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;

  localparam logic [0:0] REG_VP_WIDTH  = 1'b0;
  localparam logic [0:0] REG_VP_HEIGHT = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
  } rect_t;

  typedef struct packed {
    logic  ov;
    rect_t merged;
    rect_t clipped;
    logic  clip_ok;
  } unit_res_t;

endpackage

[rtl/drac_cell.sv]
module drac_cell import drac_pkg::*; (
  input  logic  clk,
  input  logic  shift,
  input  logic  wr,
  input  rect_t nbr,
  input  rect_t wr_data,
  output rect_t q
);

  always_ff @(posedge clk) begin
    if (wr) begin
      q <= wr_data;
    end else if (shift) begin
      q <= nbr;
    end
  end

endmodule

[rtl/drac_unit.sv]
module drac_unit import drac_pkg::*; (
  input  rect_t       head,
  input  rect_t       nrect,
  input  logic [13:0] vw,
  input  logic [13:0] vh,
  output unit_res_t   res
);

  logic signed [EXT_W-1:0] ax, ay, ar, ab, bx, by, br, bb;
  logic signed [EXT_W-1:0] mx0, my0, mr, mb;
  logic signed [EXT_W-1:0] cx0, cy0, cx1, cy1, svw, svh;
  logic signed [EXT_W-1:0] mw, mh, cw, ch;

  always_comb begin
    ax = EXT_W'(head.x);
    ay = EXT_W'(head.y);
    ar = ax + $signed({2'b00, head.w});
    ab = ay + $signed({2'b00, head.h});
    bx = EXT_W'(nrect.x);
    by = EXT_W'(nrect.y);
    br = bx + $signed({2'b00, nrect.w});
    bb = by + $signed({2'b00, nrect.h});
    svw = $signed({4'b0000, vw});
    svh = $signed({4'b0000, vh});

    res.ov = (ax < br) && (bx < ar) && (ay < bb) && (by < ab);

    // bounding box
    mx0 = (ax < bx) ? ax : bx;
    my0 = (ay < by) ? ay : by;
    mr  = (ar > br) ? ar : br;
    mb  = (ab > bb) ? ab : bb;
    mw  = mr - mx0;
    mh  = mb - my0;
    res.merged.x = mx0[COORD_W-1:0];
    res.merged.y = my0[COORD_W-1:0];
    res.merged.w = mw[SIZE_W-1:0];
    res.merged.h = mh[SIZE_W-1:0];

    // cut to [0,vw) x [0,vh)
    cx0 = (ax > 0) ? ax : '0;
    cy0 = (ay > 0) ? ay : '0;
    cx1 = (ar > svw) ? svw : ar;
    cy1 = (ab > svh) ? svh : ab;
    cw  = cx1 - cx0;
    ch  = cy1 - cy0;
    res.clip_ok = (cx1 > cx0) && (cy1 > cy0);
    res.clipped.x = cx0[COORD_W-1:0];
    res.clipped.y = cy0[COORD_W-1:0];
    res.clipped.w = cw[SIZE_W-1:0];
    res.clipped.h = ch[SIZE_W-1:0];
  end

endmodule

[rtl/damage_rect_accumulator.sv]
// Each item passes the states ST_SCAN, ST_FLUSH and ST_DONE before its result is registered;
// only one item is in flight at a time. A single compare/merge unit sits
// at the head of the rectangle ring, which sees one stored entry per cycle.
// The next item is taken while a result waits on the output register.
// Reset (rst, synchronous): table empty, full-screen flag clear, viewport 1920x1080.
module damage_rect_accumulator import drac_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                cmd,
  input  logic signed [14:0]        rect_x,
  input  logic signed [14:0]        rect_y,
  input  logic [13:0]               rect_w,
  input  logic [13:0]               rect_h,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      hit,
  output logic [AREA_W-1:0]         area_sum,
  output logic [4:0]                entry_count,
  output logic                      full_screen
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]       state;
  logic [13:0]      vw, vh;
  logic [2:0]       cmd_r;
  rect_t            nrect;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] cnt, k;
  logic             full, done, hit_acc;
  logic [PROD_W-1:0] prod;
  logic             prod_vld;
  logic [AREA_W-1:0] acc;

  rect_t            cell_q [MAX_RECTS];
  rect_t            head, wb, vp_rect;
  unit_res_t        ures;
  logic             keep, ins, merge_now, qhit, valid_i, new_ok, last;
  logic [IDX_W-1:0] pos, wpos;
  logic [AREA_W:0]  acc_sum;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_VP_HEIGHT) ? {18'd0, vh} : {18'd0, vw};

  always_ff @(posedge clk) begin
    if (rst) begin
      vw <= 14'd1920;
      vh <= 14'd1080;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_VP_WIDTH) begin
        vw <= pwdata[13:0];
      end else begin
        vh <= pwdata[13:0];
      end
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign head = cell_q[0];
  assign last = (idx == IDX_W'(MAX_RECTS - 1));
  assign valid_i = (CNT_W'(idx) < cnt);
  assign new_ok = (nrect.w != '0) && (nrect.h != '0);
  assign vp_rect = '{x: '0, y: '0, w: {2'b00, vw}, h: {2'b00, vh}};

  drac_unit u_unit (
    .head  (head),
    .nrect (nrect),
    .vw    (vw),
    .vh    (vh),
    .res   (ures)
  );

  always_comb begin
    keep = 1'b0;
    ins = 1'b0;
    merge_now = 1'b0;
    qhit = 1'b0;
    wb = head;
    pos = idx;
    case (cmd_r)
      CMD_ADD: begin
        if (valid_i) begin
          keep = 1'b1;
          if (!full && new_ok && !done && ures.ov) begin
            wb = ures.merged;
            merge_now = 1'b1;
          end
        end else if (CNT_W'(idx) == cnt && !full && new_ok && !done) begin
          keep = 1'b1;
          wb = nrect;
          ins = 1'b1;
        end
      end
      CMD_QUERY: begin
        keep = valid_i;
        qhit = valid_i && new_ok && ures.ov;
      end
      CMD_CLIP: begin
        if (full) begin
          keep = (idx == '0);
          wb = vp_rect;
          pos = '0;
        end else begin
          keep = valid_i && ures.clip_ok;
          wb = ures.clipped;
          pos = k[IDX_W-1:0];
        end
      end
      CMD_SETFULL, CMD_CLEAR: begin
        keep = 1'b0;
      end
      default: begin
        keep = valid_i;
      end
    endcase
    // the cell that lands on pos once the ring has turned all the way round
    wpos = pos + (IDX_W'(MAX_RECTS - 1) - idx);
  end

  for (genvar j = 0; j < MAX_RECTS; j++) begin : g_cell
    drac_cell u_cell (
      .clk     (clk),
      .shift   (state == ST_SCAN),
      .wr      ((state == ST_SCAN) && keep && (wpos == IDX_W'(j))),
      .nbr     (cell_q[(j + 1) % MAX_RECTS]),
      .wr_data (wb),
      .q       (cell_q[j])
    );
  end

  assign acc_sum = {1'b0, acc} + (AREA_W + 1)'(prod);

  always_ff @(posedge clk) begin
    prod <= wb.w * wb.h;
    if (state == ST_IDLE && in_valid) begin
      cmd_r <= cmd;
      nrect <= '{x: rect_x, y: rect_y, w: {2'b00, rect_w}, h: {2'b00, rect_h}};
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc_sum[AREA_W] ? {AREA_W{1'b1}} : acc_sum[AREA_W-1:0];
    end
    if (state == ST_SCAN) begin
      idx <= idx + 1'b1;
      if (keep) begin
        k <= k + 1'b1;
      end
    end else begin
      idx <= '0;
      k <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      full <= 1'b0;
      done <= 1'b0;
      hit_acc <= 1'b0;
      prod_vld <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      prod_vld <= (state == ST_SCAN) && keep;
      if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          done <= 1'b0;
          hit_acc <= 1'b0;
          if (in_valid) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (merge_now || ins) begin
            done <= 1'b1;
          end
          if (qhit) begin
            hit_acc <= 1'b1;
          end
          if (ins) begin
            cnt <= cnt + 1'b1;
          end
          if (last) begin
            state <= ST_FLUSH;
            case (cmd_r)
              CMD_ADD: begin
                // nothing merged and no room left
                if (!full && new_ok && !done && !merge_now && !ins) begin
                  full <= 1'b1;
                end
              end
              CMD_CLIP: begin
                cnt <= keep ? k + 1'b1 : k;
              end
              CMD_SETFULL: begin
                full <= 1'b1;
                cnt <= '0;
              end
              CMD_CLEAR: begin
                full <= 1'b0;
                cnt <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_FLUSH: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      hit <= (cmd_r == CMD_QUERY) && (full || hit_acc);
      area_sum <= acc;
      entry_count <= 5'(cnt);
      full_screen <= full;
    end
  end

endmodule

[rtl/drac_checker.sv]
module drac_checker import drac_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [AREA_W-1:0] area_sum,
  input logic [4:0]        entry_count
);

  // one item in flight: no transaction right after an accepted one
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(area_sum))
    else $error("result dropped while stalled");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= 5'(MAX_RECTS))
    else $error("entry count past table size");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_count == 5'd0 |-> area_sum == '0)
    else $error("area with empty table");

endmodule

bind damage_rect_accumulator drac_checker u_drac_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .area_sum    (area_sum),
  .entry_count (entry_count)
);

[verif/damage_rect_accumulator_tb.sv]
module damage_rect_accumulator_tb;
  import drac_pkg::*;

  localparam logic [2:0] CMD_AREA = 3'd5;
  localparam logic [2:0] CMD_UNK6 = 3'd6;
  localparam logic [2:0] CMD_UNK7 = 3'd7;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 3 * (MAX_RECTS + 2);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] cmd = '0;
  logic signed [14:0] rect_x = '0, rect_y = '0;
  logic [13:0] rect_w = '0, rect_h = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  logic [AREA_W-1:0] area_sum;
  logic [4:0] entry_count;
  logic full_screen;

  damage_rect_accumulator dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  typedef struct {
    logic hit;
    logic [AREA_W-1:0] area;
    logic [4:0] cnt;
    logic full;
  } damage_status_t;

  typedef struct {
    logic [2:0] cmd;
    int x, y, w, h;
    bit fixed;
    damage_status_t want;
  } damage_row_t;

  // damage table mirror
  int dmg_x[MAX_RECTS], dmg_y[MAX_RECTS], dmg_w[MAX_RECTS], dmg_h[MAX_RECTS];
  int dmg_count;
  bit dmg_full;
  int vp_w = 1920, vp_h = 1080;

  damage_status_t pending_status[$];
  int mismatches = 0;
  int stall_pct = 0;
  int idle_cycles = 0;

  function automatic bit rects_touch(int ax, int ay, int aw, int ah,
                                     int bx, int by, int bw, int bh);
    return ax < bx + bw && bx < ax + aw && ay < by + bh && by < ay + ah;
  endfunction

  function automatic logic [AREA_W-1:0] damaged_area();
    longint s;
    s = 0;
    for (int i = 0; i < dmg_count; i++) begin
      s += longint'(dmg_w[i]) * longint'(dmg_h[i]);
      if (s > 64'hF_FFFF_FFFF) s = 64'hF_FFFF_FFFF;
    end
    return s[AREA_W-1:0];
  endfunction

  function automatic damage_status_t track_damage(logic [2:0] c, int x, int y, int w, int h);
    damage_status_t r;
    bit merged;
    int k, x0, y0, x1, y1;
    r.hit = 1'b0;
    merged = 0;
    case (c)
      CMD_ADD: begin
        if (!dmg_full && w > 0 && h > 0) begin
          for (int i = 0; i < dmg_count && !merged; i++) begin
            if (rects_touch(dmg_x[i], dmg_y[i], dmg_w[i], dmg_h[i], x, y, w, h)) begin
              x0 = (dmg_x[i] < x) ? dmg_x[i] : x;
              y0 = (dmg_y[i] < y) ? dmg_y[i] : y;
              x1 = (dmg_x[i] + dmg_w[i] > x + w) ? dmg_x[i] + dmg_w[i] : x + w;
              y1 = (dmg_y[i] + dmg_h[i] > y + h) ? dmg_y[i] + dmg_h[i] : y + h;
              dmg_x[i] = x0; dmg_y[i] = y0; dmg_w[i] = x1 - x0; dmg_h[i] = y1 - y0;
              merged = 1;
            end
          end
          if (!merged) begin
            if (dmg_count >= MAX_RECTS) dmg_full = 1;
            else begin
              dmg_x[dmg_count] = x; dmg_y[dmg_count] = y;
              dmg_w[dmg_count] = w; dmg_h[dmg_count] = h;
              dmg_count++;
            end
          end
        end
      end
      CMD_QUERY: begin
        if (dmg_full) r.hit = 1'b1;
        else if (w > 0 && h > 0)
          for (int i = 0; i < dmg_count; i++)
            if (rects_touch(dmg_x[i], dmg_y[i], dmg_w[i], dmg_h[i], x, y, w, h))
              r.hit = 1'b1;
      end
      CMD_CLIP: begin
        if (dmg_full) begin
          dmg_x[0] = 0; dmg_y[0] = 0; dmg_w[0] = vp_w; dmg_h[0] = vp_h;
          dmg_count = 1;
        end else begin
          k = 0;
          for (int i = 0; i < dmg_count; i++) begin
            x0 = (dmg_x[i] > 0) ? dmg_x[i] : 0;
            y0 = (dmg_y[i] > 0) ? dmg_y[i] : 0;
            x1 = dmg_x[i] + dmg_w[i];
            y1 = dmg_y[i] + dmg_h[i];
            if (x1 > vp_w) x1 = vp_w;
            if (y1 > vp_h) y1 = vp_h;
            if (x1 > x0 && y1 > y0) begin
              dmg_x[k] = x0; dmg_y[k] = y0; dmg_w[k] = x1 - x0; dmg_h[k] = y1 - y0;
              k++;
            end
          end
          dmg_count = k;
        end
      end
      CMD_SETFULL: begin dmg_full = 1; dmg_count = 0; end
      CMD_CLEAR: begin dmg_full = 0; dmg_count = 0; end
      default: ;
    endcase
    r.area = damaged_area();
    r.cnt = dmg_count[4:0];
    r.full = dmg_full;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    damage_status_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result transaction");
      end else begin
        e = pending_status.pop_front();
        if (hit !== e.hit || area_sum !== e.area || entry_count !== e.cnt ||
            full_screen !== e.full) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: exp hit=%0d area=%0d cnt=%0d full=%0d, got %0d %0d %0d %0d",
                     e.hit, e.area, e.cnt, e.full, hit, area_sum, entry_count, full_screen);
        end
      end
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [0:0] idx, int value);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = 3'(4 * idx); pwdata = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (idx == REG_VP_WIDTH) vp_w = value & 16'h3FFF;
    else vp_h = value & 16'h3FFF;
  endtask

  task automatic wait_drained();
    while (pending_status.size() != 0) @(negedge clk);
  endtask

  // sender; called at a falling edge, returns at a falling edge
  task automatic send_item(logic [2:0] c, int x, int y, int w, int h, int gap_pct,
                           bit fixed, damage_status_t want);
    damage_status_t got;
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    cmd = c; rect_x = 15'(x); rect_y = 15'(y); rect_w = 14'(w); rect_h = 14'(h);
    do @(posedge clk); while (!in_ready);
    got = track_damage(c, int'(rect_x), int'(rect_y), int'(rect_w), int'(rect_h));
    if (fixed && (got.hit !== want.hit || got.area !== want.area ||
                  got.cnt !== want.cnt || got.full !== want.full)) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: directed row disagrees with predictor, cmd=%0d", c);
    end
    pending_status.insert(pending_status.size(), got);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic random_item(int gap_pct);
    int r, x, y, w, h;
    logic [2:0] c;
    r = $urandom_range(99);
    if ($urandom_range(9) == 0) begin
      x = $urandom; y = $urandom; w = $urandom; h = $urandom;
    end else begin
      x = $urandom_range(2400) - 300; y = $urandom_range(1500) - 300;
      w = ($urandom_range(15) == 0) ? 0 : $urandom_range(400, 1);
      h = ($urandom_range(15) == 0) ? 0 : $urandom_range(300, 1);
    end
    if (r < 50) c = CMD_ADD;
    else if (r < 70) c = CMD_QUERY;
    else if (r < 77) c = CMD_CLIP;
    else if (r < 80) c = CMD_SETFULL;
    else if (r < 88) c = CMD_CLEAR;
    else if (r < 95) c = CMD_AREA;
    else c = $urandom_range(1) ? CMD_UNK6 : CMD_UNK7;
    send_item(c, x, y, w, h, gap_pct, 0, '{default: '0});
  endtask

  damage_row_t directed[$];
  int phase_gap[4] = '{0, 69, 0, 10};
  int phase_stall[4] = '{0, 0, 69, 10};

  initial begin
    directed = '{
      '{CMD_AREA, 0, 0, 0, 0, 1, '{0, 0, 0, 0}},
      '{CMD_ADD, 5, 5, 0, 10, 1, '{0, 0, 0, 0}},
      '{CMD_ADD, -16384, -16384, 16383, 16383, 1, '{0, 36'd268402689, 1, 0}},
      '{CMD_ADD, 16383, 16383, 16383, 16383, 1, '{0, 36'd536805378, 2, 0}},
      '{CMD_QUERY, -10, -10, 5, 5, 0, '{default: '0}},
      '{CMD_QUERY, -10, -10, 0, 5, 1, '{0, 36'd536805378, 2, 0}},
      '{CMD_QUERY, 16383, -1, 1, 1, 0, '{default: '0}},
      '{CMD_ADD, -5, -5, 100, 100, 0, '{default: '0}},
      '{CMD_CLIP, 0, 0, 0, 0, 0, '{default: '0}},
      '{CMD_UNK6, 0, 0, 0, 0, 0, '{default: '0}},
      '{CMD_UNK7, -1, -1, 16383, 16383, 0, '{default: '0}},
      '{CMD_SETFULL, 0, 0, 0, 0, 1, '{0, 0, 0, 1}},
      '{CMD_ADD, 10, 10, 10, 10, 1, '{0, 0, 0, 1}},
      '{CMD_QUERY, 0, 0, 0, 0, 1, '{1, 0, 0, 1}},
      '{CMD_CLIP, 0, 0, 0, 0, 1, '{0, 36'd2073600, 1, 1}},
      '{CMD_CLEAR, 0, 0, 0, 0, 1, '{0, 0, 0, 0}}
    };
    // fill the table with disjoint rectangles, the last one overflows it
    for (int i = 0; i <= MAX_RECTS; i++)
      directed.insert(directed.size(), '{CMD_ADD, i * 50, 7, 20, 20, 0, '{default: '0}});
    directed.insert(directed.size(), '{CMD_CLIP, 0, 0, 0, 0, 0, '{default: '0}});
    directed.insert(directed.size(), '{CMD_CLEAR, 0, 0, 0, 0, 1, '{0, 0, 0, 0}});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    write_reg(REG_VP_WIDTH, 1920);
    write_reg(REG_VP_HEIGHT, 1080);
    foreach (directed[i])
      send_item(directed[i].cmd, directed[i].x, directed[i].y, directed[i].w,
                directed[i].h, 0, directed[i].fixed, directed[i].want);

    for (int p = 0; p < 4; p++) begin
      wait_drained();
      repeat (4) @(negedge clk);
      case (p)
        0: begin write_reg(REG_VP_WIDTH, 0); write_reg(REG_VP_HEIGHT, 16383); end
        1: begin write_reg(REG_VP_WIDTH, 16383); write_reg(REG_VP_HEIGHT, 0); end
        2: begin
          write_reg(REG_VP_WIDTH, $urandom_range(4000));
          write_reg(REG_VP_HEIGHT, $urandom_range(3000));
        end
        default: begin write_reg(REG_VP_WIDTH, 1920); write_reg(REG_VP_HEIGHT, 1080); end
      endcase
      stall_pct = phase_stall[p];
      for (int n = 0; n < 260; n++) begin
        if (p == 1 && n == 130) wait_drained();
        random_item(phase_gap[p]);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

[damage_rect_accumulator.f]
rtl/drac_pkg.sv
rtl/drac_cell.sv
rtl/drac_unit.sv
rtl/damage_rect_accumulator.sv
rtl/drac_checker.sv
verif/damage_rect_accumulator_tb.sv
